// ----- rtl/core/swt_pkg.sv -----
// ---------------------------------------------------------------------------
// swt_pkg: shared types, codes and byte classifier for the word tokenizer
// Holds the tokenizer state and result record types, the byte and code
// constants, and the per-byte classification used by the decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swt_pkg;

    // Special bytes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    // Quote mode codes
    localparam logic [1:0] QM_NONE   = 2'd0;
    localparam logic [1:0] QM_SINGLE = 2'd1;
    localparam logic [1:0] QM_DOUBLE = 2'd2;

    // Pending escape codes
    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_PLAIN = 2'd1;
    localparam logic [1:0] ESC_DQ    = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_EOW  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Results per input item and result queue depth
    localparam int MAX_RES = 3;
    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic [1:0] qm;
        logic [1:0] esc;
        logic       has;   // current word holds a byte
        logic       raw;   // no quote byte since the last word
    } t_state;

    localparam t_state ST_RESET = '{qm: QM_NONE, esc: ESC_NONE, has: 1'b0, raw: 1'b1};

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       unq;
        logic       last;
    } t_res;

    typedef struct packed {
        logic   vld;
        t_res   res;
        t_state st;
    } t_plain;

    function automatic t_res mk_res(input logic [1:0] kind, input logic [7:0] ch,
                                    input logic unq);
        t_res r;
        r.kind = kind;
        r.ch   = ch;
        r.unq  = unq;
        r.last = 1'b0;
        return r;
    endfunction

    // Handle one byte with no escape pending.
    function automatic t_plain plain_byte(input logic [7:0] c, input t_state s);
        t_plain     p;
        logic       in_q;
        logic [1:0] mode;
        p.vld  = 1'b0;
        p.res  = mk_res(KIND_BYTE, c, 1'b0);
        p.st   = s;
        in_q   = (s.qm == QM_SINGLE) || (s.qm == QM_DOUBLE);
        mode   = (c == CH_SQUOTE) ? QM_SINGLE : QM_DOUBLE;
        if (c == CH_SPACE) begin
            if (in_q) begin
                p.vld    = 1'b1;
                p.st.has = 1'b1;
            end else if (s.has) begin
                p.vld    = 1'b1;
                p.res    = mk_res(KIND_EOW, 8'd0, s.raw);
                p.st.has = 1'b0;
                p.st.raw = 1'b1;
            end
        end else if (c == CH_BSLASH) begin
            if (s.qm == QM_SINGLE) begin
                p.vld    = 1'b1;
                p.st.has = 1'b1;
            end else if (s.qm == QM_DOUBLE) begin
                p.st.esc = ESC_DQ;
            end else begin
                p.st.esc = ESC_PLAIN;
            end
        end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
            p.st.raw = 1'b0;
            if (!in_q) begin
                p.st.qm = mode;
            end else if (s.qm == mode) begin
                p.st.qm = QM_NONE;
            end else begin
                p.vld    = 1'b1;
                p.st.has = 1'b1;
            end
        end else begin
            p.vld    = 1'b1;
            p.st.has = 1'b1;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/swt_decode.sv -----
// ---------------------------------------------------------------------------
// swt_decode: per-byte tokenizer decode
// From the current state and one input item, forms up to three results in
// order, marks the final one, and gives the next state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swt_decode
    import swt_pkg::*;
(
    input  wire t_state     i_state,
    input  wire logic [7:0] i_char,
    input  wire logic       i_line_end,
    output t_res            o_res [MAX_RES],
    output logic [1:0]      o_cnt,
    output t_state          o_next
);

    t_state     s_clr;
    t_state     s_pl;
    t_plain     pl;
    t_res       cand [MAX_RES];
    logic [2:0] cv;
    logic [1:0] cnt;

    always_comb begin
        s_clr     = i_state;
        s_clr.esc = ESC_NONE;
        s_pl      = s_clr;
        // the escaped-out backslash already made the word non-empty
        if (i_state.esc == ESC_DQ) begin
            s_pl.has = 1'b1;
        end
        pl = plain_byte(i_char, s_pl);
    end

    always_comb begin
        cv      = '0;
        cand[0] = mk_res(KIND_BYTE, i_char, 1'b0);
        cand[1] = mk_res(KIND_BYTE, i_char, 1'b0);
        cand[2] = mk_res(KIND_DONE, 8'd0, 1'b0);
        o_next  = s_clr;
        if (i_line_end) begin
            cv[0]   = (i_state.esc == ESC_DQ);
            cand[0] = mk_res(KIND_BYTE, CH_BSLASH, 1'b0);
            cv[1]   = i_state.has || (i_state.esc == ESC_DQ);
            cand[1] = mk_res(KIND_EOW, 8'd0, i_state.raw);
            cv[2]   = 1'b1;
            o_next  = ST_RESET;
        end else if (i_state.esc == ESC_PLAIN) begin
            cv[0]      = 1'b1;
            o_next.has = 1'b1;
        end else if (i_state.esc == ESC_DQ) begin
            cv[0] = 1'b1;
            if ((i_char == CH_DQUOTE) || (i_char == CH_BSLASH)) begin
                o_next.has = 1'b1;
            end else begin
                // keep the backslash, then treat the byte normally
                cand[0] = mk_res(KIND_BYTE, CH_BSLASH, 1'b0);
                cv[1]   = pl.vld;
                cand[1] = pl.res;
                o_next  = pl.st;
            end
        end else begin
            cv[0]   = pl.vld;
            cand[0] = pl.res;
            o_next  = pl.st;
        end
    end

    // Compact valid candidates to the front and flag the final one.
    always_comb begin
        cnt = 2'd0;
        for (int i = 0; i < MAX_RES; i++) begin
            o_res[i] = cand[i];
        end
        for (int i = 0; i < MAX_RES; i++) begin
            if (cv[i]) begin
                o_res[cnt] = cand[i];
                cnt        = cnt + 2'd1;
            end
        end
        if (cnt != 2'd0) begin
            o_res[cnt - 2'd1].last = 1'b1;
        end
        o_cnt = cnt;
    end

endmodule

`default_nettype wire

// ----- rtl/core/swt_outq.sv -----
// ---------------------------------------------------------------------------
// swt_outq: result queue
// Shift queue of results; takes up to three per cycle, presents the head
// from a register, and drops the head on each output transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swt_outq
    import swt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_res       i_res [MAX_RES],
    input  wire logic [1:0] i_push_n,
    output logic            o_room,
    output logic            o_valid,
    output t_res            o_head,
    input  wire logic       i_pop
);

    t_res       r_q [Q_DEPTH];
    logic [2:0] r_cnt;
    t_res       n_q [Q_DEPTH];
    logic [2:0] n_cnt;
    logic [2:0] keep;
    logic [2:0] rel;
    logic       pop;

    assign o_valid = (r_cnt != 3'd0);
    assign o_head  = r_q[0];
    assign pop     = i_pop && o_valid;
    // room for a full set of results from one item
    assign o_room  = (r_cnt <= 3'(Q_DEPTH - MAX_RES));
    assign keep    = r_cnt - {2'd0, pop};
    assign n_cnt   = keep + {1'b0, i_push_n};

    always_comb begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            rel = 3'(i) - keep;
            if (pop && (i < Q_DEPTH - 1)) begin
                n_q[i] = r_q[(i + 1) % Q_DEPTH];
            end else begin
                n_q[i] = r_q[i];
            end
            if ((3'(i) >= keep) && (rel < {1'b0, i_push_n})) begin
                n_q[i] = i_res[rel[1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(Q_DEPTH))
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |-> (n_cnt <= 3'(Q_DEPTH)))
        else $error("result queue overflow");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (i_push_n == 2'd0)) |=> (r_cnt == $past(r_cnt) - 3'd1))
        else $error("result queue pop lost");

endmodule

`default_nettype wire

// ----- rtl/core/shell_word_tokenizer_top.sv -----
// ---------------------------------------------------------------------------
// shell_word_tokenizer_top: shell-style word splitter for a byte stream
// Splits a command line into words, honoring single quotes, double quotes
// and backslash escapes, and emits word bytes, word ends and line ends.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel: one transaction per command-line byte in tdata; tlast
//   marks the line-end item (tdata ignored), which closes the pending word,
//   answers "line done" and returns the tokenizer to its reset state.
//   Master channel: one transaction per result. tuser gives the kind
//   (word byte, end of word, line done); tdata carries the byte and, on an
//   end of word, a flag that no quote appeared since the previous word;
//   tlast marks the final result caused by an input item.
//   Each item yields zero to three results. The decode runs in the cycle
//   of the input transaction and writes results into a four-entry queue;
//   results are registered there before they appear on the master channel.
//   Throughput: one item per cycle while each item yields at most one
//   result and the receiver keeps up; s_axis_tready drops while more than
//   one result waits in the queue, so an item with two or three results
//   holds off the next item until the queue drains.
//   Reset (i_rst_n low, synchronous) empties the queue and clears the
//   tokenizer state. When the receiver stalls, the head result holds and
//   input stops once the queue cannot take a full set of results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shell_word_tokenizer_top
    import swt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave channel
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  wire logic        i_s_axis_tlast,   // line_end
    // master channel
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [7:0] out_char, [8] word_unquoted, zero pad
    output logic [1:0]       o_m_axis_tuser,   // [1:0] kind
    output logic             o_m_axis_tlast    // last result of the item
);

    t_state     r_st;
    t_state     n_st;
    t_res       dec_res [MAX_RES];
    logic [1:0] dec_cnt;
    logic [1:0] push_n;
    logic       accept;
    logic       room;
    t_res       head;

    // Accept an item only when the queue can hold everything it may yield.
    assign o_s_axis_tready = room;
    assign accept          = i_s_axis_tvalid && room;
    assign push_n          = accept ? dec_cnt : 2'd0;

    swt_decode u_decode (
        .i_state    (r_st),
        .i_char     (i_s_axis_tdata),
        .i_line_end (i_s_axis_tlast),
        .o_res      (dec_res),
        .o_cnt      (dec_cnt),
        .o_next     (n_st)
    );

    // Advance the tokenizer state on each input transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RESET;
        end else if (accept) begin
            r_st <= n_st;
        end
    end

    swt_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res    (dec_res),
        .i_push_n (push_n),
        .o_room   (room),
        .o_valid  (o_m_axis_tvalid),
        .o_head   (head),
        .i_pop    (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {7'd0, head.unq, head.ch};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

    a_line_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_axis_tlast) |=> (r_st == ST_RESET))
        else $error("line end did not reset tokenizer state");

    a_item_yields_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_axis_tlast) |-> (dec_cnt != 2'd0))
        else $error("line end produced no result");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
             && $stable(o_m_axis_tlast)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
